### hdl/lsmq_pkg.sv
// ----------------------------------------------------------------------------
// lsmq_pkg
// Shared types and constants of the linked-slot message queue: pool size,
// field widths, status and state codes, payload and store command structs.
// ----------------------------------------------------------------------------
package lsmq_pkg;

   // Pool size and derived widths
   localparam int SLOTS  = 16;
   localparam int SLOT_W = $clog2(SLOTS + 1);
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int LEN_W  = 13;
   localparam int TYPE_W = 32;

   localparam logic [LEN_W-1:0] MAX_MSG_RESET = LEN_W'(1024 * 4);

   // Register port
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam int REG_IDX_W = CSR_AW - 2;
   localparam logic [REG_IDX_W-1:0] REG_MAX_MSG = '0;

   // Operation codes
   localparam logic MODE_SEND = 1'b0;
   localparam logic MODE_RECV = 1'b1;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_TOO_LONG  = 3'd1,
      ST_NO_FREE   = 3'd2,
      ST_EMPTY     = 3'd3,
      ST_TOO_SHORT = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_LOOKUP,
      SEQ_APPLY,
      SEQ_DONE
   } seq_state_type;

   // Request and response payloads
   typedef struct packed {
      logic              mode;
      logic [LEN_W-1:0]  msg_len;
      logic [TYPE_W-1:0] msg_tag;
      logic [LEN_W-1:0]  recv_capacity;
   } req_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot;
      logic [LEN_W-1:0]  out_len;
      logic [TYPE_W-1:0] out_type;
      logic [SLOT_W-1:0] ready_level;
   } rsp_type;

   // Sequencer to slot store
   typedef struct packed {
      logic              rd_en;
      logic [SLOT_W-1:0] rd_slot;
      logic              link_wr_en;
      logic [SLOT_W-1:0] link_wr_slot;
      logic [SLOT_W-1:0] link_wr_val;
      logic              msg_wr_en;
      logic [SLOT_W-1:0] msg_wr_slot;
      logic [LEN_W-1:0]  msg_wr_len;
      logic [TYPE_W-1:0] msg_wr_type;
   } store_cmd_type;

   // Slot store read data
   typedef struct packed {
      logic [SLOT_W-1:0] link;
      logic [LEN_W-1:0]  len;
      logic [TYPE_W-1:0] msg_tag;
   } store_rd_type;

endpackage

### hdl/lsmq_store.sv
// ----------------------------------------------------------------------------
// lsmq_store
// Slot store: next-link memory with per-entry valid bits that stand in for
// its reset chain, and the length and type memories. One registered read
// port and write ports addressed by slot number.
// ----------------------------------------------------------------------------
module lsmq_store
   import lsmq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  store_cmd_type cmd,
   output store_rd_type  rd
);

   logic [SLOT_W-1:0] link_mem [SLOTS];
   logic [LEN_W-1:0]  len_mem  [SLOTS];
   logic [TYPE_W-1:0] type_mem [SLOTS];
   logic [SLOTS-1:0]  link_vld_ff;

   logic [SLOT_W-1:0] link_rd_ff;
   logic [LEN_W-1:0]  len_rd_ff;
   logic [TYPE_W-1:0] type_rd_ff;

   logic [IDX_W-1:0]  rd_idx;
   logic [IDX_W-1:0]  link_wr_idx;
   logic [IDX_W-1:0]  msg_wr_idx;

   // Chain value of an entry that was never written: next slot, last ends
   function automatic logic [SLOT_W-1:0] link_init(input logic [IDX_W-1:0] idx);
      logic [SLOT_W-1:0] nxt;
      nxt = SLOT_W'(idx) + SLOT_W'(2);
      if (SLOT_W'(idx) == SLOT_W'(SLOTS - 1)) begin
         nxt = '0;
      end
      return nxt;
   endfunction

   // Map slot numbers 1..SLOTS onto entries 0..SLOTS-1
   assign rd_idx      = IDX_W'(cmd.rd_slot - SLOT_W'(1));
   assign link_wr_idx = IDX_W'(cmd.link_wr_slot - SLOT_W'(1));
   assign msg_wr_idx  = IDX_W'(cmd.msg_wr_slot - SLOT_W'(1));

   // Track which links have been written since reset
   always_ff @(posedge clock) begin
      if (reset) begin
         link_vld_ff <= '0;
      end else if (cmd.link_wr_en) begin
         link_vld_ff[link_wr_idx] <= 1'b1;
      end
   end

   // Write and read the link memory
   always_ff @(posedge clock) begin
      if (cmd.link_wr_en) begin
         link_mem[link_wr_idx] <= cmd.link_wr_val;
      end
      if (cmd.rd_en) begin
         link_rd_ff <= link_vld_ff[rd_idx] ? link_mem[rd_idx] : link_init(rd_idx);
      end
   end

   // Write and read the message length and type memories
   always_ff @(posedge clock) begin
      if (cmd.msg_wr_en) begin
         len_mem[msg_wr_idx]  <= cmd.msg_wr_len;
         type_mem[msg_wr_idx] <= cmd.msg_wr_type;
      end
      if (cmd.rd_en) begin
         len_rd_ff  <= len_mem[rd_idx];
         type_rd_ff <= type_mem[rd_idx];
      end
   end

   assign rd.link    = link_rd_ff;
   assign rd.len     = len_rd_ff;
   assign rd.msg_tag = type_rd_ff;

endmodule

### hdl/lsmq_ctrl.sv
// ----------------------------------------------------------------------------
// lsmq_ctrl
// Sequencer: holds the stack heads and counts, steps one transaction through
// lookup and apply with a single shared length comparator, and presents the
// finished result until the output register takes it.
// ----------------------------------------------------------------------------
module lsmq_ctrl
   import lsmq_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   input  logic [LEN_W-1:0] max_msg_size,
   input  logic             out_free,
   output logic             res_valid,
   output rsp_type          res_data,
   output store_cmd_type    cmd,
   input  store_rd_type     rd
);

   seq_state_type     state_ff, state_in;
   req_type           item_ff, item_in;
   rsp_type           res_ff, res_in;
   logic [SLOT_W-1:0] free_head_ff, free_head_in;
   logic [SLOT_W-1:0] ready_head_ff, ready_head_in;
   logic [SLOT_W-1:0] free_count_ff, free_count_in;
   logic [SLOT_W-1:0] ready_count_ff, ready_count_in;

   // Shared comparator
   logic [LEN_W-1:0]  cmp_a;
   logic [LEN_W-1:0]  cmp_b;
   logic              cmp_gt;

   assign cmp_gt = cmp_a > cmp_b;

   // State, heads and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= SEQ_IDLE;
         free_head_ff   <= SLOT_W'(1);
         ready_head_ff  <= '0;
         free_count_ff  <= SLOT_W'(SLOTS);
         ready_count_ff <= '0;
      end else begin
         state_ff       <= state_in;
         free_head_ff   <= free_head_in;
         ready_head_ff  <= ready_head_in;
         free_count_ff  <= free_count_in;
         ready_count_ff <= ready_count_in;
      end
   end

   // Held transaction and its result
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      res_ff  <= res_in;
   end

   // Next state, stack updates and store commands
   always_comb begin
      state_in       = state_ff;
      item_in        = item_ff;
      res_in         = res_ff;
      free_head_in   = free_head_ff;
      ready_head_in  = ready_head_ff;
      free_count_in  = free_count_ff;
      ready_count_in = ready_count_ff;
      req_ready      = 1'b0;
      cmp_a          = item_ff.msg_len;
      cmp_b          = max_msg_size;
      cmd            = '0;

      case (state_ff)
         SEQ_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               item_in  = req_data;
               state_in = SEQ_LOOKUP;
            end
         end

         SEQ_LOOKUP: begin
            res_in             = '0;
            res_in.ready_level = ready_count_ff;
            if (item_ff.mode == MODE_SEND) begin
               // Check the limit first, then the free stack
               if (cmp_gt) begin
                  res_in.status = ST_TOO_LONG;
                  state_in      = SEQ_DONE;
               end else if (free_count_ff == '0) begin
                  res_in.status = ST_NO_FREE;
                  state_in      = SEQ_DONE;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_slot = free_head_ff;
                  state_in    = SEQ_APPLY;
               end
            end else begin
               if (ready_count_ff == '0) begin
                  res_in.status = ST_EMPTY;
                  state_in      = SEQ_DONE;
               end else begin
                  cmd.rd_en   = 1'b1;
                  cmd.rd_slot = ready_head_ff;
                  state_in    = SEQ_APPLY;
               end
            end
         end

         SEQ_APPLY: begin
            cmp_a    = rd.len;
            cmp_b    = item_ff.recv_capacity;
            state_in = SEQ_DONE;
            if (item_ff.mode == MODE_SEND) begin
               // Move the free head onto the ready stack and fill it
               cmd.msg_wr_en    = 1'b1;
               cmd.msg_wr_slot  = free_head_ff;
               cmd.msg_wr_len   = item_ff.msg_len;
               cmd.msg_wr_type  = item_ff.msg_tag;
               cmd.link_wr_en   = 1'b1;
               cmd.link_wr_slot = free_head_ff;
               cmd.link_wr_val  = ready_head_ff;
               free_head_in     = rd.link;
               ready_head_in    = free_head_ff;
               free_count_in    = free_count_ff - SLOT_W'(1);
               ready_count_in   = ready_count_ff + SLOT_W'(1);
               res_in.status      = ST_OK;
               res_in.slot        = free_head_ff;
               res_in.ready_level = ready_count_ff + SLOT_W'(1);
            end else if (cmp_gt) begin
               // Leave the slot on top of the ready stack
               res_in.status = ST_TOO_SHORT;
               res_in.slot   = ready_head_ff;
            end else begin
               // Move the ready head onto the free stack and return it
               cmd.link_wr_en   = 1'b1;
               cmd.link_wr_slot = ready_head_ff;
               cmd.link_wr_val  = free_head_ff;
               free_head_in     = ready_head_ff;
               ready_head_in    = rd.link;
               free_count_in    = free_count_ff + SLOT_W'(1);
               ready_count_in   = ready_count_ff - SLOT_W'(1);
               res_in.status      = ST_OK;
               res_in.slot        = ready_head_ff;
               res_in.out_len     = rd.len;
               res_in.out_type    = rd.msg_tag;
               res_in.ready_level = ready_count_ff - SLOT_W'(1);
            end
         end

         SEQ_DONE: begin
            if (out_free) begin
               state_in = SEQ_IDLE;
            end
         end

         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   assign res_valid = (state_ff == SEQ_DONE);
   assign res_data  = res_ff;

endmodule

### hdl/linked_slot_message_queue.sv
// ----------------------------------------------------------------------------
// linked_slot_message_queue
// Message slot pool with free and ready stacks chained through one link
// table; sends store length and type, receives pop the newest message.
//
//   channel  ports                      direction  moves
//   req      req_valid/ready, req_data  in         one send or receive
//   rsp      rsp_valid/ready, rsp_data  out        one result per request
//   csr      psel/penable/pwrite/...    in/out     max_msg_size at 0x0
//
// A request that reaches the link table passes through lookup, apply and
// done before the next acceptance; one rejected on its length or an empty
// stack goes from lookup straight to done. The sequence is set by the link
// memory's registered read followed by the link write-back. Reset is
// synchronous and restores the full free chain without a clearing pass.
// While the result register is held by rsp_ready low, one further request
// can be worked up to its result and then waits.
// ----------------------------------------------------------------------------
module linked_slot_message_queue
   import lsmq_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [CSR_DW-1:0] pwdata,
   output logic [CSR_DW-1:0] prdata,
   output logic              pready
);

   logic [LEN_W-1:0]     max_msg_ff, max_msg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 csr_wr;
   logic                 out_free;
   logic                 res_valid;
   rsp_type              res_data;
   store_cmd_type        cmd;
   store_rd_type         rd;

   // Register port decode
   assign pready  = 1'b1;
   assign reg_idx = paddr[CSR_AW-1:2];
   assign csr_wr  = psel && penable && pwrite && pready;

   always_comb begin
      max_msg_in = max_msg_ff;
      if (csr_wr && (reg_idx == REG_MAX_MSG)) begin
         max_msg_in = pwdata[LEN_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (reg_idx == REG_MAX_MSG) begin
         prdata = CSR_DW'(max_msg_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_msg_ff <= MAX_MSG_RESET;
      end else begin
         max_msg_ff <= max_msg_in;
      end
   end

   // Result register: load a finished result once the previous one is taken
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_free) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_data_in = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   lsmq_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .max_msg_size (max_msg_ff),
      .out_free     (out_free),
      .res_valid    (res_valid),
      .res_data     (res_data),
      .cmd          (cmd),
      .rd           (rd)
   );

   lsmq_store u_store (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .rd    (rd)
   );

endmodule

### hdl/lsmq_checker.sv
// ----------------------------------------------------------------------------
// lsmq_checker
// Port-level checks of the message queue, bound to the top level.
// ----------------------------------------------------------------------------
module lsmq_checker
   import lsmq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Drop ready for the cycle after a transaction is accepted
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted on consecutive cycles");

   // Report no slot and no data on send rejections and on an empty receive
   a_reject_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == ST_TOO_LONG || rsp_data.status == ST_NO_FREE
                    || rsp_data.status == ST_EMPTY)
      |-> rsp_data.slot == '0 && rsp_data.out_len == '0 && rsp_data.out_type == '0)
      else $error("rejected transaction carries slot or data");

   // An empty queue reports no waiting messages
   a_empty_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == ST_EMPTY |-> rsp_data.ready_level == '0)
      else $error("empty status with messages waiting");

   // Keep the ready level within the pool
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.ready_level <= SLOT_W'(SLOTS))
      else $error("ready level beyond pool size");

endmodule

bind linked_slot_message_queue lsmq_checker u_lsmq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
